// ===== rtl/core/bra_pkg.sv =====
// Shared types, constants and helpers for the banker's resource allocator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package bra_pkg;

   localparam int CUSTOMERS  = 8;
   localparam int RESOURCES  = 4;
   localparam int COUNT_BITS = 8;

   localparam int COUNT_W = COUNT_BITS;
   localparam int CUST_W  = (CUSTOMERS > 1) ? $clog2(CUSTOMERS) : 1;
   localparam int RES_W   = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int NC_W    = $clog2(CUSTOMERS + 1);
   localparam int NR_W    = $clog2(RESOURCES + 1);
   localparam int WORK_W  = COUNT_BITS + $clog2(CUSTOMERS) + 1;
   localparam int DEPTH   = CUSTOMERS * RESOURCES;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [COUNT_W-1:0] CMAX = {COUNT_W{1'b1}};

   // Command codes on req_command
   localparam logic [2:0] CMD_LOAD_MAX  = 3'd0;
   localparam logic [2:0] CMD_LOAD_FREE = 3'd1;
   localparam logic [2:0] CMD_REQUEST   = 3'd2;
   localparam logic [2:0] CMD_RELEASE   = 3'd3;
   localparam logic [2:0] CMD_DETECT    = 3'd4;

   // Status codes on rsp_status
   localparam logic [2:0] STAT_ACCEPTED = 3'd0;
   localparam logic [2:0] STAT_GRANTED  = 3'd1;
   localparam logic [2:0] STAT_DENIED   = 3'd2;
   localparam logic [2:0] STAT_NO_DEAD  = 3'd3;
   localparam logic [2:0] STAT_BROKEN   = 3'd4;
   localparam logic [2:0] STAT_REJECTED = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_MODE      = 2'd0;
   localparam logic [1:0] CSR_CUSTOMERS = 2'd1;
   localparam logic [1:0] CSR_RESOURCES = 2'd2;

   typedef enum logic [2:0] {
      OP_RESULT    = 3'd0,
      OP_LOAD_MAX  = 3'd1,
      OP_LOAD_FREE = 3'd2,
      OP_STORE     = 3'd3,
      OP_DECIDE    = 3'd4,
      OP_RELEASE   = 3'd5,
      OP_DETECT    = 3'd6
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [2:0]          status;
      logic [CUST_W-1:0]   cust;
      logic [RES_W-1:0]    res;
      logic [COUNT_W-1:0]  amt;
   } entry_type;

   typedef struct packed {
      logic [COUNT_W-1:0] max_claim;
      logic [COUNT_W-1:0] held_count;
      logic [COUNT_W-1:0] still_needed;
      logic [COUNT_W-1:0] pending_request;
   } word_type;

   function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                  input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_W] ? CMAX : s[COUNT_W-1:0];
   endfunction

   function automatic logic [COUNT_W-1:0] floor_sub(input logic [COUNT_W-1:0] a,
                                                    input logic [COUNT_W-1:0] b);
      return (a > b) ? (a - b) : '0;
   endfunction

   function automatic logic [COUNT_W-1:0] sat_amount(input logic [7:0] a);
      return (32'(a) > 32'(CMAX)) ? CMAX : COUNT_W'(a);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bra_front.sv =====
// Front end: takes a command, checks its indexes and sorts it into an operation.
// Depends on bra_pkg.
`default_nettype none
module bra_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [2:0]            command,
   input  wire logic [2:0]            customer_index,
   input  wire logic [1:0]            resource_index,
   input  wire logic [7:0]            amount,
   input  wire logic                  last_element,
   input  wire logic [bra_pkg::NC_W-1:0] nc,
   input  wire logic [bra_pkg::NR_W-1:0] nr,
   output logic                       push,
   output bra_pkg::entry_type         entry
);
   import bra_pkg::*;

   logic      push_ff, push_in;
   entry_type entry_ff, entry_in;
   logic      c_ok, r_ok;

   always_comb begin
      c_ok = 32'(customer_index) < 32'(nc);
      r_ok = 32'(resource_index) < 32'(nr);
      entry_in.cust   = CUST_W'(customer_index);
      entry_in.res    = RES_W'(resource_index);
      entry_in.amt    = sat_amount(amount);
      entry_in.status = STAT_DENIED;
      entry_in.op     = OP_RESULT;
      case (command)
         CMD_LOAD_MAX: begin
            if (c_ok && r_ok) entry_in.op = OP_LOAD_MAX;
            else entry_in.status = STAT_REJECTED;
         end
         CMD_LOAD_FREE: begin
            if (r_ok) entry_in.op = OP_LOAD_FREE;
            else entry_in.status = STAT_REJECTED;
         end
         CMD_REQUEST: begin
            if (c_ok && r_ok) entry_in.op = last_element ? OP_DECIDE : OP_STORE;
         end
         CMD_RELEASE: begin
            if (c_ok) entry_in.op = OP_RELEASE;
         end
         CMD_DETECT: entry_in.op = OP_DETECT;
         default: entry_in.op = OP_RESULT;
      endcase
      push_in = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) push_ff <= 1'b0;
      else push_ff <= push_in;
      if (accept) entry_ff <= entry_in;
   end

   assign push  = push_ff;
   assign entry = entry_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bra_queue.sv =====
// Short FIFO of classified operations between the front end and the engine.
// Depends on bra_pkg.
`default_nettype none
module bra_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  bra_pkg::entry_type push_entry,
   input  wire logic          pop,
   output logic               valid,
   output bra_pkg::entry_type head
);
   import bra_pkg::*;

   entry_type          slot_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic               do_pop;

   always_comb begin
      do_pop = pop && (cnt_ff != '0);
      wr_in  = push ? ((32'(wr_ff) == QDEPTH - 1) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((32'(rd_ff) == QDEPTH - 1) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   assign valid = cnt_ff != '0;
   assign head  = slot_ff[rd_ff];
endmodule
`default_nettype wire

// ===== rtl/core/bra_back.sv =====
// Engine: runs loads, requests, releases, safety walks and detection over the
// per-customer table, one table element at a time. Depends on bra_pkg.
`default_nettype none
module bra_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     mode,
   input  wire logic [bra_pkg::NC_W-1:0] nc,
   input  wire logic [bra_pkg::NR_W-1:0] nr,
   input  wire logic                     q_valid,
   input  bra_pkg::entry_type            q_entry,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_status,
   output logic [2:0]                    rsp_victim
);
   import bra_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_STORE    = 11'b000_0000_0010,
      S_CHECK    = 11'b000_0000_0100,
      S_APPLY    = 11'b000_0000_1000,
      S_INIT     = 11'b000_0001_0000,
      S_WALK     = 11'b000_0010_0000,
      S_OUTCOME  = 11'b000_0100_0000,
      S_ROLLBACK = 11'b000_1000_0000,
      S_RELEASE  = 11'b001_0000_0000,
      S_ZERO     = 11'b010_0000_0000,
      S_VICTIM   = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   entry_type           cmd_ff, cmd_in;
   logic [CUST_W-1:0]   cust_ff, cust_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic                ex_ff, ex_in, fits_ff, fits_in, prog_ff, prog_in, nz_ff, nz_in;
   logic [WORK_W-1:0]   work_ff [RESOURCES];
   logic [WORK_W-1:0]   work_in [RESOURCES];
   logic [COUNT_W-1:0]  tmp_ff [RESOURCES];
   logic [COUNT_W-1:0]  tmp_in [RESOURCES];
   logic [COUNT_W-1:0]  free_ff [RESOURCES];
   logic [COUNT_W-1:0]  free_in [RESOURCES];
   logic [CUSTOMERS-1:0] flag_ff, flag_in;
   logic                rsp_v_ff, rsp_v_in;
   logic [2:0]          status_ff, status_in, victim_ff, victim_in;

   word_type            mem [DEPTH];
   logic [DEPTH-1:0]    valid_ff;
   word_type            rd_ff, wdata;
   logic                mem_we;
   logic [ADDR_W-1:0]   addr;

   logic                last_res, last_cust, adv_cust, gained, all_done, too_big;
   logic [CUST_W-1:0]   first_open;
   logic [COUNT_W-1:0]  want, give, held_new;

   assign addr = ADDR_W'(32'(cust_ff) * RESOURCES + 32'(res_ff));

   always_comb begin
      state_in = state_ff;  cmd_in  = cmd_ff;  cust_in = cust_ff;  res_in = res_ff;
      ex_in    = ex_ff;     fits_in = fits_ff; prog_in = prog_ff;  nz_in  = nz_ff;
      work_in  = work_ff;   tmp_in  = tmp_ff;  free_in = free_ff;  flag_in = flag_ff;
      rsp_v_in = 1'b0;      status_in = status_ff;  victim_in = victim_ff;
      pop      = 1'b0;      mem_we  = 1'b0;    wdata  = rd_ff;
      adv_cust = 1'b0;      gained  = 1'b0;    give   = '0;  held_new = '0;

      last_res  = (NR_W'(res_ff) + NR_W'(1)) == nr;
      last_cust = (NC_W'(cust_ff) + NC_W'(1)) == nc;
      want      = (cmd_ff.op == OP_DECIDE) ? rd_ff.still_needed : rd_ff.pending_request;
      too_big   = WORK_W'(want) > work_ff[res_ff];

      all_done   = 1'b1;
      first_open = '0;
      for (int i = CUSTOMERS - 1; i >= 0; i--) begin
         if (i < int'(nc) && !flag_ff[i]) begin
            all_done   = 1'b0;
            first_open = CUST_W'(i);
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               pop     = 1'b1;
               cmd_in  = q_entry;
               cust_in = q_entry.cust;
               res_in  = q_entry.res;
               ex_in   = 1'b0;
               fits_in = 1'b1;
               prog_in = 1'b0;
               nz_in   = 1'b0;
               victim_in = '0;
               case (q_entry.op)
                  OP_RESULT: begin
                     rsp_v_in = 1'b1; status_in = q_entry.status;
                  end
                  OP_LOAD_FREE: begin
                     free_in[q_entry.res] = q_entry.amt;
                     rsp_v_in = 1'b1; status_in = STAT_ACCEPTED;
                  end
                  OP_LOAD_MAX: begin
                     if (q_entry.amt > free_ff[q_entry.res]) begin
                        rsp_v_in = 1'b1; status_in = STAT_REJECTED;
                     end else state_in = S_STORE;
                  end
                  OP_STORE, OP_DECIDE: state_in = S_STORE;
                  OP_RELEASE: begin
                     res_in = '0; state_in = S_RELEASE;
                  end
                  OP_DETECT: begin
                     cust_in = '0; res_in = '0; state_in = S_ZERO;
                  end
                  default: begin
                     rsp_v_in = 1'b1; status_in = STAT_DENIED;
                  end
               endcase
            end
         end
         S_STORE: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               mem_we = 1'b1;
               ex_in  = 1'b0;
               if (cmd_ff.op == OP_LOAD_MAX) begin
                  wdata.max_claim    = cmd_ff.amt;
                  wdata.still_needed = floor_sub(cmd_ff.amt, rd_ff.held_count);
               end else wdata.pending_request = cmd_ff.amt;
               if (cmd_ff.op == OP_DECIDE) begin
                  res_in = '0; state_in = S_CHECK;
               end else begin
                  rsp_v_in = 1'b1; status_in = STAT_ACCEPTED; state_in = S_IDLE;
               end
            end
         end
         S_CHECK: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in = 1'b0;
               if (rd_ff.pending_request > free_ff[res_ff] ||
                   (!mode && rd_ff.pending_request > rd_ff.still_needed)) begin
                  rsp_v_in = 1'b1; status_in = STAT_DENIED; state_in = S_IDLE;
               end else if (last_res) begin
                  res_in = '0; state_in = S_APPLY;
               end else res_in = res_ff + 1'b1;
            end
         end
         S_APPLY: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in  = 1'b0;
               mem_we = 1'b1;
               free_in[res_ff] = free_ff[res_ff] - rd_ff.pending_request;
               if (!mode) begin
                  wdata.held_count   = rd_ff.held_count + rd_ff.pending_request;
                  wdata.still_needed = rd_ff.still_needed - rd_ff.pending_request;
               end else begin
                  held_new = sat_add(rd_ff.held_count, rd_ff.pending_request);
                  wdata.held_count   = held_new;
                  wdata.still_needed = floor_sub(rd_ff.max_claim, held_new);
               end
               if (last_res) begin
                  if (!mode) state_in = S_INIT;
                  else begin
                     rsp_v_in = 1'b1; status_in = STAT_GRANTED; state_in = S_IDLE;
                  end
               end else res_in = res_ff + 1'b1;
            end
         end
         S_INIT: begin
            for (int k = 0; k < RESOURCES; k++) work_in[k] = WORK_W'(free_ff[k]);
            if (cmd_ff.op != OP_DETECT) flag_in = '0;
            cust_in = '0; res_in = '0; ex_in = 1'b0; fits_in = 1'b1; prog_in = 1'b0;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (!ex_ff && flag_ff[cust_ff]) adv_cust = 1'b1;
            else if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in = 1'b0;
               tmp_in[res_ff] = rd_ff.held_count;
               if (too_big) fits_in = 1'b0;
               if (last_res) begin
                  adv_cust = 1'b1;
                  if (fits_ff && !too_big) begin
                     gained = 1'b1;
                     flag_in[cust_ff] = 1'b1;
                     for (int k = 0; k < RESOURCES; k++) begin
                        if (k < int'(nr)) begin
                           work_in[k] = work_ff[k] + WORK_W'((RES_W'(k) == res_ff) ?
                                        rd_ff.held_count : tmp_ff[k]);
                        end
                     end
                  end
               end else res_in = res_ff + 1'b1;
            end
            if (adv_cust) begin
               res_in  = '0;
               fits_in = 1'b1;
               prog_in = prog_ff | gained;
               if (last_cust) begin
                  cust_in = '0;
                  if (prog_ff || gained) prog_in = 1'b0;
                  else state_in = S_OUTCOME;
               end else cust_in = cust_ff + 1'b1;
            end
         end
         S_OUTCOME: begin
            res_in = '0; ex_in = 1'b0;
            if (cmd_ff.op == OP_DETECT) begin
               if (all_done) begin
                  rsp_v_in = 1'b1; status_in = STAT_NO_DEAD; state_in = S_IDLE;
               end else begin
                  cust_in = first_open; state_in = S_VICTIM;
               end
            end else begin
               if (all_done) begin
                  rsp_v_in = 1'b1; status_in = STAT_GRANTED; state_in = S_IDLE;
               end else begin
                  cust_in = cmd_ff.cust; state_in = S_ROLLBACK;
               end
            end
         end
         S_ROLLBACK: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in  = 1'b0;
               mem_we = 1'b1;
               free_in[res_ff]    = free_ff[res_ff] + rd_ff.pending_request;
               wdata.held_count   = rd_ff.held_count - rd_ff.pending_request;
               wdata.still_needed = rd_ff.still_needed + rd_ff.pending_request;
               if (last_res) begin
                  rsp_v_in = 1'b1; status_in = STAT_DENIED; state_in = S_IDLE;
               end else res_in = res_ff + 1'b1;
            end
         end
         S_RELEASE: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in  = 1'b0;
               mem_we = 1'b1;
               give   = (rd_ff.pending_request > rd_ff.held_count) ?
                        rd_ff.held_count : rd_ff.pending_request;
               held_new = rd_ff.held_count - give;
               free_in[res_ff]       = sat_add(free_ff[res_ff], give);
               wdata.held_count      = held_new;
               wdata.still_needed    = floor_sub(rd_ff.max_claim, held_new);
               wdata.pending_request = '0;
               if (last_res) begin
                  rsp_v_in = 1'b1; status_in = STAT_ACCEPTED; state_in = S_IDLE;
               end else res_in = res_ff + 1'b1;
            end
         end
         S_ZERO: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in = 1'b0;
               if (last_res) begin
                  flag_in[cust_ff] = !(nz_ff || rd_ff.held_count != '0);
                  nz_in  = 1'b0;
                  res_in = '0;
                  if (last_cust) state_in = S_INIT;
                  else cust_in = cust_ff + 1'b1;
               end else begin
                  nz_in  = nz_ff || rd_ff.held_count != '0;
                  res_in = res_ff + 1'b1;
               end
            end
         end
         S_VICTIM: begin
            if (!ex_ff) ex_in = 1'b1;
            else begin
               ex_in  = 1'b0;
               mem_we = 1'b1;
               free_in[res_ff]       = sat_add(free_ff[res_ff], rd_ff.held_count);
               wdata.held_count      = '0;
               wdata.still_needed    = rd_ff.max_claim;
               wdata.pending_request = '0;
               if (last_res) begin
                  rsp_v_in = 1'b1; status_in = STAT_BROKEN;
                  victim_in = 3'(cust_ff); state_in = S_IDLE;
               end else res_in = res_ff + 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ex_ff    <= 1'b0;
         fits_ff  <= 1'b1;
         prog_ff  <= 1'b0;
         nz_ff    <= 1'b0;
         flag_ff  <= '0;
         rsp_v_ff <= 1'b0;
         valid_ff <= '0;
         for (int k = 0; k < RESOURCES; k++) free_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         ex_ff    <= ex_in;
         fits_ff  <= fits_in;
         prog_ff  <= prog_in;
         nz_ff    <= nz_in;
         flag_ff  <= flag_in;
         rsp_v_ff <= rsp_v_in;
         free_ff  <= free_in;
         if (mem_we) valid_ff[addr] <= 1'b1;
      end
      cmd_ff    <= cmd_in;
      cust_ff   <= cust_in;
      res_ff    <= res_in;
      work_ff   <= work_in;
      tmp_ff    <= tmp_in;
      status_ff <= status_in;
      victim_ff <= victim_in;
   end

   // Table memory: one read and one write port, registered read data.
   always_ff @(posedge clock) begin
      if (mem_we) mem[addr] <= wdata;
      rd_ff <= valid_ff[addr] ? mem[addr] : '0;
   end

   assign rsp_valid  = rsp_v_ff;
   assign rsp_status = status_ff;
   assign rsp_victim = victim_ff;
endmodule
`default_nettype wire

// ===== rtl/core/bankers_resource_allocator.sv =====
// Banker's resource allocator. The safety and detection walks read the table memory
// one element at a time through its read port, in at most nc+1 passes, and make a
// final request element or a detection the longest operations.
// One item at a time: busy stays high from accept until its result strobe.
// Synchronous active-high reset clears all counts and tables and sets the configuration to its defaults.
`default_nettype none
module bankers_resource_allocator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_command,
   input  wire logic [2:0] req_customer_index,
   input  wire logic [1:0] req_resource_index,
   input  wire logic [7:0] req_amount,
   input  wire logic       req_last_element,
   output logic            rsp_valid,
   output logic [2:0]      rsp_status,
   output logic [2:0]      rsp_victim_customer,
   input  wire logic       csr_write_enable,
   input  wire logic [1:0] csr_index,
   input  wire logic [3:0] csr_write_data
);
   import bra_pkg::*;

   logic              mode_ff, mode_in;
   logic [3:0]        cust_cfg_ff, cust_cfg_in;
   logic [2:0]        res_cfg_ff, res_cfg_in;
   logic              inflight_ff, inflight_in;
   logic [NC_W-1:0]   nc;
   logic [NR_W-1:0]   nr;
   logic              accept, push, q_valid, pop;
   entry_type         push_entry, q_entry;

   // Hold configuration; writes must land only while idle: the user ensures it, the block does not enforce it.
   always_comb begin
      mode_in     = mode_ff;
      cust_cfg_in = cust_cfg_ff;
      res_cfg_in  = res_cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_MODE:      mode_in     = csr_write_data[0];
            CSR_CUSTOMERS: cust_cfg_in = csr_write_data;
            CSR_RESOURCES: res_cfg_in  = csr_write_data[2:0];
            default:       mode_in     = mode_ff;
         endcase
      end
   end

   // Clamp active counts into 1..CUSTOMERS and 1..RESOURCES.
   always_comb begin
      if (cust_cfg_ff == '0) nc = NC_W'(1);
      else if (32'(cust_cfg_ff) > CUSTOMERS) nc = NC_W'(CUSTOMERS);
      else nc = NC_W'(cust_cfg_ff);
      if (res_cfg_ff == '0) nr = NR_W'(1);
      else if (32'(res_cfg_ff) > RESOURCES) nr = NR_W'(RESOURCES);
      else nr = NR_W'(res_cfg_ff);
   end

   // Raise busy on accept, drop it with the result strobe.
   assign accept = start && !inflight_ff;
   always_comb begin
      inflight_in = inflight_ff;
      if (accept) inflight_in = 1'b1;
      else if (rsp_valid) inflight_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         cust_cfg_ff <= 4'd8;
         res_cfg_ff  <= 3'd4;
         inflight_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         cust_cfg_ff <= cust_cfg_in;
         res_cfg_ff  <= res_cfg_in;
         inflight_ff <= inflight_in;
      end
   end

   assign busy = inflight_ff;

   bra_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_command),
      .customer_index (req_customer_index),
      .resource_index (req_resource_index),
      .amount         (req_amount),
      .last_element   (req_last_element),
      .nc             (nc),
      .nr             (nr),
      .push           (push),
      .entry          (push_entry)
   );

   bra_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .valid      (q_valid),
      .head       (q_entry)
   );

   bra_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode_ff),
      .nc         (nc),
      .nr         (nr),
      .q_valid    (q_valid),
      .q_entry    (q_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_victim (rsp_victim_customer)
   );
endmodule
`default_nettype wire

// ===== rtl/core/bra_checker.sv =====
// Port-level checks for the banker's resource allocator, bound to the top level.
// Depends on bra_pkg.
`default_nettype none
module bra_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic       rsp_valid,
   input wire logic [2:0] rsp_status,
   input wire logic [2:0] rsp_victim_customer
);
   import bra_pkg::*;

   a_rsp_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result without an item in flight");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("two results for one item");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_BROKEN |-> rsp_victim_customer == 3'd0)
      else $error("victim set without a broken deadlock");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STAT_REJECTED) else $error("undefined status");
endmodule

bind bankers_resource_allocator bra_checker u_bra_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_status          (rsp_status),
   .rsp_victim_customer (rsp_victim_customer)
);
`default_nettype wire

// ===== tb/sv/bankers_resource_allocator_tb.sv =====
// Self-checking testbench for the banker's resource allocator.
// Depends on bra_pkg and bankers_resource_allocator; predicts every status and victim.
`timescale 1ns / 1ps
module bankers_resource_allocator_tb;
   import bra_pkg::*;

   typedef struct {
      logic [2:0] command;
      logic [2:0] cust;
      logic [1:0] res;
      logic [7:0] amount;
      logic       last;
      bit         csr;       // configuration write, applied only while idle
      logic [1:0] csr_idx;
      logic [3:0] csr_data;
      bit         drain;     // hold until every expected result has come
      int         idle_pct;  // sender idle percentage from here on
   } item_type;

   typedef struct {
      logic [2:0] status;
      logic [2:0] victim;
   } answer_type;

   logic clock = 0, reset = 1, start = 0;
   logic busy, rsp_valid;
   logic [2:0] req_command = '0, req_customer_index = '0;
   logic [1:0] req_resource_index = '0;
   logic [7:0] req_amount = '0;
   logic       req_last_element = 0;
   logic [2:0] rsp_status, rsp_victim_customer;
   logic       csr_write_enable = 0;
   logic [1:0] csr_index = '0;
   logic [3:0] csr_write_data = '0;

   bankers_resource_allocator u_dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   // Predictor state, a private copy of the block's tables
   logic       mode_q;
   logic [3:0] ncust_q;
   logic [2:0] nres_q;
   logic [7:0] free_q [RESOURCES];
   logic [7:0] max_q [CUSTOMERS][RESOURCES];
   logic [7:0] held_q [CUSTOMERS][RESOURCES];
   logic [7:0] need_q [CUSTOMERS][RESOURCES];
   logic [7:0] pend_q [CUSTOMERS][RESOURCES];
   bit         done_q [CUSTOMERS];

   item_type   pending_items [$];
   answer_type expected_answers [$];
   int errors = 0, results_seen = 0, grants = 0, denials = 0, breaks = 0;
   int idle_pct = 0, watchdog = 0;
   int idle_pct_next = 0;
   bit stim_done = 0;

   function automatic int clampi(int v, int top);
      return v < 1 ? 1 : (v > top ? top : v);
   endfunction

   // Mark every customer that can finish with the given work vector.
   function automatic void finish_walk(int nc, int nr, ref int work [RESOURCES], input bit by_need);
      bit moved;
      bit fits;
      int want;
      moved = 1;
      while (moved) begin
         moved = 0;
         for (int i = 0; i < nc; i++) begin
            if (!done_q[i]) begin
               fits = 1;
               for (int j = 0; j < nr; j++) begin
                  want = by_need ? need_q[i][j] : pend_q[i][j];
                  if (want > work[j]) fits = 0;
               end
               if (fits) begin
                  for (int j = 0; j < nr; j++) work[j] += held_q[i][j];
                  done_q[i] = 1;
                  moved = 1;
               end
            end
         end
      end
   endfunction

   function automatic logic [7:0] sat8(int v);
      return v > 255 ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] fsub(int a, int b);
      return a > b ? 8'(a - b) : 8'd0;
   endfunction

   function automatic logic [2:0] grant_decision(int c, int nc, int nr);
      int work [RESOURCES];
      bit safe;
      if (mode_q == 0) begin
         for (int j = 0; j < nr; j++)
            if (pend_q[c][j] > need_q[c][j] || pend_q[c][j] > free_q[j]) return STAT_DENIED;
         for (int j = 0; j < nr; j++) begin
            free_q[j] -= pend_q[c][j];
            held_q[c][j] += pend_q[c][j];
            need_q[c][j] -= pend_q[c][j];
         end
         for (int j = 0; j < nr; j++) work[j] = free_q[j];
         for (int i = 0; i < nc; i++) done_q[i] = 0;
         finish_walk(nc, nr, work, 1);
         safe = 1;
         for (int i = 0; i < nc; i++) if (!done_q[i]) safe = 0;
         if (!safe) begin
            // roll the tentative grant back
            for (int j = 0; j < nr; j++) begin
               free_q[j] += pend_q[c][j];
               held_q[c][j] -= pend_q[c][j];
               need_q[c][j] += pend_q[c][j];
            end
            return STAT_DENIED;
         end
         return STAT_GRANTED;
      end
      for (int j = 0; j < nr; j++) if (pend_q[c][j] > free_q[j]) return STAT_DENIED;
      for (int j = 0; j < nr; j++) begin
         free_q[j] -= pend_q[c][j];
         held_q[c][j] = sat8(held_q[c][j] + pend_q[c][j]);
         need_q[c][j] = fsub(max_q[c][j], held_q[c][j]);
      end
      return STAT_GRANTED;
   endfunction

   function automatic answer_type predict_answer(item_type it);
      answer_type a;
      int nc, nr, work [RESOURCES], sum, give;
      bit c_ok, r_ok;
      nc = clampi(ncust_q, CUSTOMERS);
      nr = clampi(nres_q, RESOURCES);
      c_ok = it.cust < nc;
      r_ok = it.res < nr;
      a.status = STAT_DENIED;
      a.victim = '0;
      case (it.command)
         CMD_LOAD_MAX: begin
            if (!c_ok || !r_ok || it.amount > free_q[it.res]) a.status = STAT_REJECTED;
            else begin
               max_q[it.cust][it.res] = it.amount;
               need_q[it.cust][it.res] = fsub(it.amount, held_q[it.cust][it.res]);
               a.status = STAT_ACCEPTED;
            end
         end
         CMD_LOAD_FREE: begin
            if (!r_ok) a.status = STAT_REJECTED;
            else begin
               free_q[it.res] = it.amount;
               a.status = STAT_ACCEPTED;
            end
         end
         CMD_REQUEST: begin
            if (c_ok && r_ok) begin
               pend_q[it.cust][it.res] = it.amount;
               a.status = it.last ? grant_decision(it.cust, nc, nr) : STAT_ACCEPTED;
            end
         end
         CMD_RELEASE: begin
            if (c_ok) begin
               for (int j = 0; j < nr; j++) begin
                  give = pend_q[it.cust][j] > held_q[it.cust][j] ?
                         held_q[it.cust][j] : pend_q[it.cust][j];
                  held_q[it.cust][j] -= give;
                  free_q[j] = sat8(free_q[j] + give);
                  need_q[it.cust][j] = fsub(max_q[it.cust][j], held_q[it.cust][j]);
                  pend_q[it.cust][j] = 0;
               end
               a.status = STAT_ACCEPTED;
            end
         end
         CMD_DETECT: begin
            for (int j = 0; j < nr; j++) work[j] = free_q[j];
            for (int i = 0; i < nc; i++) begin
               sum = 0;
               for (int j = 0; j < nr; j++) sum += held_q[i][j];
               done_q[i] = (sum == 0);
            end
            finish_walk(nc, nr, work, 0);
            a.status = STAT_NO_DEAD;
            for (int i = 0; i < nc; i++) begin
               if (!done_q[i] && a.status == STAT_NO_DEAD) begin
                  // free everything the first deadlocked customer holds
                  for (int j = 0; j < nr; j++) begin
                     free_q[j] = sat8(free_q[j] + held_q[i][j]);
                     held_q[i][j] = 0;
                     need_q[i][j] = max_q[i][j];
                     pend_q[i][j] = 0;
                  end
                  a.victim = i[2:0];
                  a.status = STAT_BROKEN;
               end
            end
         end
         default: ;
      endcase
      return a;
   endfunction

   // Driver: present items at the falling edge; csr writes and drains wait for idle.
   int settle = 0;
   always @(negedge clock) begin
      bit wr_en;
      wr_en = 0;
      if (reset) begin
         start <= 0;
      end else begin
         if (start) start <= 0;   // the previous item was accepted at the last edge
         if (settle > 0) settle <= settle - 1;
         else if (pending_items.size() > 0 && !(start && busy)) begin
            if (pending_items[0].csr || pending_items[0].drain) begin
               if (expected_answers.size() == 0 && !busy && !start) begin
                  if (pending_items[0].csr) begin
                     wr_en = 1;
                     csr_index <= pending_items[0].csr_idx;
                     csr_write_data <= pending_items[0].csr_data;
                     case (pending_items[0].csr_idx)
                        CSR_MODE: mode_q = pending_items[0].csr_data[0];
                        CSR_CUSTOMERS: ncust_q = pending_items[0].csr_data;
                        CSR_RESOURCES: nres_q = pending_items[0].csr_data[2:0];
                        default: ;
                     endcase
                  end
                  idle_pct = pending_items[0].idle_pct;
                  void'(pending_items.pop_front());
                  settle <= 2;
               end
            end else if (!start && !busy && $urandom_range(99) >= idle_pct) begin
               req_command <= pending_items[0].command;
               req_customer_index <= pending_items[0].cust;
               req_resource_index <= pending_items[0].res;
               req_amount <= pending_items[0].amount;
               req_last_element <= pending_items[0].last;
               start <= 1;
            end
         end
      end
      csr_write_enable <= wr_en;
   end

   // Accept at the rising edge: start high and busy low; predict immediately.
   always @(posedge clock) begin
      item_type it;
      if (!reset) begin
         if (start && !busy) begin
            it = pending_items.pop_front();
            expected_answers.push_back(predict_answer(it));
         end
         if (start && busy) $display("%t driver held start while busy", $time);
      end
   end

   // Monitor: compare each strobed result with the oldest expectation.
   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (expected_answers.size() == 0) begin
            errors++;
            $display("%t unexpected result status=%0d victim=%0d", $time, rsp_status,
                     rsp_victim_customer);
         end else begin
            e = expected_answers.pop_front();
            case (e.status)
               STAT_GRANTED: grants++;
               STAT_DENIED: denials++;
               STAT_BROKEN: breaks++;
               default: ;
            endcase
            if (rsp_status !== e.status) begin
               errors++;
               $display("%t status mismatch: expected %0d actual %0d", $time, e.status,
                        rsp_status);
            end
            if (rsp_victim_customer !== e.victim) begin
               errors++;
               $display("%t victim mismatch: expected %0d actual %0d", $time, e.victim,
                        rsp_victim_customer);
            end
         end
      end
   end

   function automatic item_type cmd_item(logic [2:0] c, logic [2:0] k, logic [1:0] r,
                                         logic [7:0] a, logic l);
      item_type it;
      it = '{default: 0};
      it.command = c; it.cust = k; it.res = r; it.amount = a; it.last = l;
      return it;
   endfunction

   task automatic push_csr(logic [1:0] idx, logic [3:0] data);
      item_type it;
      it = '{default: 0};
      it.csr = 1; it.csr_idx = idx; it.csr_data = data; it.idle_pct = idle_pct_next;
      pending_items.push_back(it);
   endtask

   task automatic push_phase(int pct);
      item_type it;
      it = '{default: 0};
      it.drain = 1; it.idle_pct = pct;
      idle_pct_next = pct;
      pending_items.push_back(it);
   endtask

   // A scenario: free counts, claims, then whole requests, releases, detections and random commands.
   task automatic push_scenario(int nc, int nr);
      int n;
      for (int j = 0; j < nr; j++)
         pending_items.push_back(cmd_item(CMD_LOAD_FREE, 3'd0, 2'(j),
                                          8'($urandom_range(3, 12)), 1'b0));
      for (int i = 0; i < nc; i++)
         for (int j = 0; j < nr; j++)
            pending_items.push_back(cmd_item(CMD_LOAD_MAX, 3'(i), 2'(j),
                                             8'($urandom_range(0, 6)), 1'b0));
      n = $urandom_range(4, 10);
      for (int k = 0; k < n; k++) begin
         int c;
         c = $urandom_range(nc - 1);
         case ($urandom_range(9))
            0, 1: pending_items.push_back(cmd_item(CMD_RELEASE, 3'(c), 2'd0, 8'd0, 1'b0));
            2: pending_items.push_back(cmd_item(CMD_DETECT, 3'd0, 2'd0, 8'd0, 1'b0));
            3: pending_items.push_back(cmd_item(3'($urandom_range(7)), 3'($urandom_range(7)),
                  2'($urandom_range(3)), 8'($urandom), 1'($urandom_range(1))));
            default:
               for (int j = 0; j < nr; j++)
                  pending_items.push_back(cmd_item(CMD_REQUEST, 3'(c), 2'(j),
                     8'($urandom_range(3) == 0 ? $urandom : $urandom_range(0, 3)),
                     j == nr - 1));
         endcase
      end
   endtask

   int total_items;
   initial begin
      int nc, nr, phase;
      for (int j = 0; j < RESOURCES; j++) free_q[j] = 0;
      for (int i = 0; i < CUSTOMERS; i++) begin
         done_q[i] = 0;
         for (int j = 0; j < RESOURCES; j++) begin
            max_q[i][j] = 0; held_q[i][j] = 0; need_q[i][j] = 0; pend_q[i][j] = 0;
         end
      end
      mode_q = 0; ncust_q = 8; nres_q = 4;

      // Directed: extremes, every command, rejections, unknown codes, deadlock break.
      pending_items.push_back(cmd_item(CMD_DETECT, 0, 0, 0, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_MAX, 7, 3, 8'd1, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_FREE, 3, 3, 8'd255, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_MAX, 7, 3, 8'd255, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_FREE, 0, 0, 8'd2, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_MAX, 0, 0, 8'd2, 0));
      pending_items.push_back(cmd_item(CMD_REQUEST, 0, 0, 8'd3, 1));
      pending_items.push_back(cmd_item(CMD_REQUEST, 7, 3, 8'd255, 1));
      pending_items.push_back(cmd_item(CMD_RELEASE, 7, 0, 0, 0));
      pending_items.push_back(cmd_item(3'd5, 0, 0, 0, 0));
      pending_items.push_back(cmd_item(3'd6, 5, 2, 8'hAA, 1));
      pending_items.push_back(cmd_item(3'd7, 2, 1, 8'h55, 0));
      push_phase(0);
      push_csr(CSR_MODE, 4'd1);
      push_csr(CSR_CUSTOMERS, 4'd2);
      push_csr(CSR_RESOURCES, 4'd1);
      pending_items.push_back(cmd_item(CMD_LOAD_MAX, 2, 0, 0, 0));
      pending_items.push_back(cmd_item(CMD_LOAD_FREE, 0, 1, 0, 0));
      pending_items.push_back(cmd_item(CMD_REQUEST, 0, 0, 8'd1, 1));
      pending_items.push_back(cmd_item(CMD_REQUEST, 1, 0, 8'd1, 1));
      pending_items.push_back(cmd_item(CMD_REQUEST, 0, 0, 8'd1, 0));
      pending_items.push_back(cmd_item(CMD_REQUEST, 1, 0, 8'd1, 0));
      pending_items.push_back(cmd_item(CMD_DETECT, 0, 0, 0, 0));
      pending_items.push_back(cmd_item(CMD_REQUEST, 3, 0, 0, 1));

      // Random phases over settings, including clamped register values 0 and 15/7.
      phase = 0;
      while (pending_items.size() < 1250) begin
         case (phase % 4)
            0: push_phase(0);
            1: push_phase(60);
            2: push_phase(33);
            default: push_phase($urandom_range(1) ? 0 : 60);
         endcase
         push_csr(CSR_MODE, 4'($urandom_range(1)));
         nc = $urandom_range(15);
         nr = $urandom_range(7);
         push_csr(CSR_CUSTOMERS, 4'(nc));
         push_csr(CSR_RESOURCES, 4'(nr));
         for (int s = 0; s < 6 && pending_items.size() < 1250; s++)
            push_scenario(clampi(nc, CUSTOMERS), clampi(nr, RESOURCES));
         phase++;
      end
      push_phase(0);
      total_items = pending_items.size();

      repeat (4) @(posedge clock);
      @(negedge clock) reset = 0;
   end

   // End of run or watchdog: count cycles with no accepted item and no result.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) watchdog <= 0;
      else watchdog <= watchdog + 1;
      if (!reset && pending_items.size() == 0 && expected_answers.size() == 0 && !stim_done)
         stim_done <= 1;
      if (watchdog > 20000) begin
         $display("timeout: no item or result for %0d cycles", watchdog);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      repeat (2000) @(posedge clock);
      $display("Checked %0d results over %0d queued items; %0d grants, %0d denials,",
               results_seen, total_items, grants, denials);
      $display("%0d deadlocks broken, both strategies and clamped configurations.", breaks);
      if (errors == 0 && expected_answers.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
